/* rtl/spq_pkg.sv */
package spq_pkg;

    localparam int PRI_W          = 7;
    localparam int EXT_TAG_W      = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CMD_FIFO_DEPTH = 2;

    // request codes on the input channel
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LIST   = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MAX = 2'd1;

    localparam logic [PRI_W-1:0] PRIORITY_MIN_RST = 7'd15;
    localparam logic [PRI_W-1:0] PRIORITY_MAX_RST = 7'd89;

    // classified operations handed from front to back
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_REMOVE    = 2'd1;
    localparam logic [1:0] OP_LIST      = 2'd2;
    localparam logic [1:0] OP_RANGE_ERR = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [PRI_W-1:0] pri;
    } cmd_t;

endpackage

/* rtl/spq_front.sv */
module spq_front #(
    parameter int TAG_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [spq_pkg::EXT_TAG_W-1:0]      entry_tag,
    input  logic [spq_pkg::PRI_W-1:0]          entry_priority,
    input  logic                               cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spq_pkg::PRI_W-1:0]          cfg_data,
    input  logic                               fifo_full,
    output logic                               push,
    output spq_pkg::cmd_t                      cmd,
    output logic [TAG_BITS-1:0]                cmd_tag
);
    import spq_pkg::*;

    logic [PRI_W-1:0] pri_min_reg;
    logic [PRI_W-1:0] pri_max_reg;
    logic             out_of_window;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pri_min_reg <= PRIORITY_MIN_RST;
            pri_max_reg <= PRIORITY_MAX_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PRIORITY_MIN)
            begin
                pri_min_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PRIORITY_MAX)
            begin
                pri_max_reg <= cfg_data;
            end
        end
    end

    assign in_stall      = fifo_full;
    assign out_of_window = (entry_priority < pri_min_reg) || (entry_priority > pri_max_reg);

    // unused request code is swallowed here and never reaches the back end
    assign push    = in_valid && !fifo_full && (req_type != REQ_NONE);
    assign cmd_tag = TAG_BITS'(entry_tag);

    always_comb
    begin
        cmd.pri = entry_priority;
        unique case (req_type)
            REQ_INSERT: cmd.op = out_of_window ? OP_RANGE_ERR : OP_INSERT;
            REQ_REMOVE: cmd.op = OP_REMOVE;
            REQ_LIST:   cmd.op = OP_LIST;
            default:    cmd.op = OP_LIST;
        endcase
    end

endmodule

/* rtl/spq_fifo.sv */
module spq_fifo #(
    parameter int WIDTH = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    import spq_pkg::*;

    localparam int DEPTH = CMD_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/spq_back.sv */
module spq_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  spq_pkg::cmd_t                 cmd,
    input  logic [TAG_BITS-1:0]           cmd_tag,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [spq_pkg::EXT_TAG_W-1:0] out_tag,
    output logic [spq_pkg::PRI_W-1:0]     out_priority,
    output logic                          last
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {S_IDLE, S_LIST} state_t;
    typedef enum logic [1:0] {MV_HOLD, MV_INSERT, MV_SHIFT, MV_ROTATE} move_t;

    logic [TAG_BITS-1:0]  slot_tag_reg  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  slot_tag_next [QUEUE_DEPTH];
    logic [PRI_W-1:0]     slot_pri_reg  [QUEUE_DEPTH];
    logic [PRI_W-1:0]     slot_pri_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] ge;

    state_t               state_reg, state_next;
    move_t                move;
    logic [OCC_W-1:0]     occ_reg, occ_next;
    logic [OCC_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [EXT_TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [PRI_W-1:0]     out_pri_reg, out_pri_next;
    logic                 last_reg, last_next;
    logic                 out_free;
    logic [OCC_W-1:0]     occ_last;

    assign out_free     = !out_valid_reg || !out_stall;
    assign occ_last     = occ_reg - 1'b1;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_pri_reg;
    assign last         = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_free;
        status_next    = status_reg;
        out_tag_next   = out_tag_reg;
        out_pri_next   = out_pri_reg;
        last_next      = last_reg;
        move           = MV_HOLD;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    out_tag_next   = '0;
                    out_pri_next   = '0;
                    last_next      = 1'b1;
                    case (cmd.op)
                        OP_RANGE_ERR:
                        begin
                            status_next = ST_RANGE;
                        end
                        OP_INSERT:
                        begin
                            if (occ_reg == OCC_W'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                move     = MV_INSERT;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_tag_next = EXT_TAG_W'(slot_tag_reg[0]);
                                out_pri_next = slot_pri_reg[0];
                                move         = MV_SHIFT;
                                occ_next     = occ_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // list rotates the occupied slots through the head
                                out_tag_next = EXT_TAG_W'(slot_tag_reg[0]);
                                out_pri_next = slot_pri_reg[0];
                                last_next    = (occ_reg == OCC_W'(1));
                                move         = MV_ROTATE;
                                if (occ_reg != OCC_W'(1))
                                begin
                                    state_next = S_LIST;
                                    cnt_next   = OCC_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    out_tag_next   = EXT_TAG_W'(slot_tag_reg[0]);
                    out_pri_next   = slot_pri_reg[0];
                    last_next      = (cnt_reg == occ_last);
                    move           = MV_ROTATE;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == occ_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            out_tag_reg   <= '0;
            out_pri_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            out_tag_reg   <= out_tag_next;
            out_pri_reg   <= out_pri_next;
            last_reg      <= last_next;
        end
    end

    // one cell per slot: each compares its own priority and picks from its neighbors
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        localparam logic [OCC_W-1:0] IDX = OCC_W'(i);

        logic                prev_ge;
        logic [TAG_BITS-1:0] prev_tag;
        logic [PRI_W-1:0]    prev_pri;
        logic [TAG_BITS-1:0] succ_tag;
        logic [PRI_W-1:0]    succ_pri;

        assign ge[i] = (IDX < occ_reg) && (slot_pri_reg[i] >= cmd.pri);

        if (i == 0)
        begin : g_head
            assign prev_ge  = 1'b1;
            assign prev_tag = slot_tag_reg[i];
            assign prev_pri = slot_pri_reg[i];
        end
        else
        begin : g_body
            assign prev_ge  = ge[i-1];
            assign prev_tag = slot_tag_reg[i-1];
            assign prev_pri = slot_pri_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign succ_tag = slot_tag_reg[i];
            assign succ_pri = slot_pri_reg[i];
        end
        else
        begin : g_inner
            assign succ_tag = slot_tag_reg[i+1];
            assign succ_pri = slot_pri_reg[i+1];
        end

        always_comb
        begin
            slot_tag_next[i] = slot_tag_reg[i];
            slot_pri_next[i] = slot_pri_reg[i];
            case (move)
                MV_INSERT:
                begin
                    if (!ge[i])
                    begin
                        if (prev_ge)
                        begin
                            slot_tag_next[i] = cmd_tag;
                            slot_pri_next[i] = cmd.pri;
                        end
                        else
                        begin
                            slot_tag_next[i] = prev_tag;
                            slot_pri_next[i] = prev_pri;
                        end
                    end
                end
                MV_SHIFT:
                begin
                    slot_tag_next[i] = succ_tag;
                    slot_pri_next[i] = succ_pri;
                end
                MV_ROTATE:
                begin
                    if (IDX == occ_last)
                    begin
                        slot_tag_next[i] = slot_tag_reg[0];
                        slot_pri_next[i] = slot_pri_reg[0];
                    end
                    else if (IDX < occ_last)
                    begin
                        slot_tag_next[i] = succ_tag;
                        slot_pri_next[i] = succ_pri;
                    end
                end
                default:
                begin
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            slot_tag_reg[i] <= slot_tag_next[i];
            slot_pri_reg[i] <= slot_pri_next[i];
        end
    end

endmodule

/* rtl/stable_priority_queue_top.sv */
// an accepted item passes the command queue before its first result is registered
// back end takes one item per cycle for insert and remove while out_stall is low
// a list shows one stored entry per result, as the slots rotate through the head
// a two-entry command queue sits between the accepting front and the slot array
// reset clears occupancy, the command queue and the output register; the window
// registers return to 15 and 89, slot contents are left as they are
module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     req_type,
    input  logic [spq_pkg::EXT_TAG_W-1:0]  entry_tag,
    input  logic [spq_pkg::PRI_W-1:0]      entry_priority,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [spq_pkg::EXT_TAG_W-1:0]  out_tag,
    output logic [spq_pkg::PRI_W-1:0]      out_priority,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spq_pkg::PRI_W-1:0]      cfg_data
);
    import spq_pkg::*;

    localparam int CMD_W = $bits(cmd_t) + TAG_BITS;

    logic                push;
    logic                fifo_full;
    logic                fifo_not_empty;
    logic                cmd_pop;
    cmd_t                front_cmd;
    logic [TAG_BITS-1:0] front_tag;
    cmd_t                back_cmd;
    logic [TAG_BITS-1:0] back_tag;
    logic [CMD_W-1:0]    fifo_rd_data;

    spq_front #(
        .TAG_BITS(TAG_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_tag      (entry_tag),
        .entry_priority (entry_priority),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fifo_full      (fifo_full),
        .push           (push),
        .cmd            (front_cmd),
        .cmd_tag        (front_tag)
    );

    spq_fifo #(
        .WIDTH(CMD_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   ({front_cmd, front_tag}),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .rd_data   (fifo_rd_data),
        .not_empty (fifo_not_empty)
    );

    assign {back_cmd, back_tag} = fifo_rd_data;

    spq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (fifo_not_empty),
        .cmd_pop      (cmd_pop),
        .cmd          (back_cmd),
        .cmd_tag      (back_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .last         (last)
    );

endmodule

/* rtl/spq_checker.sv */
module spq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [spq_pkg::EXT_TAG_W-1:0] out_tag,
    input logic [spq_pkg::PRI_W-1:0]     out_priority,
    input logic                          last
);
    import spq_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_tag)
            && $stable(out_priority) && $stable(last))
        else $error("result changed while stalled");

    // error results end their request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("error result without last");

    // error results carry no entry
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_tag == '0 && out_priority == '0)
        else $error("error result carries an entry");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);

/* tb/sv/tb_stable_priority_queue_top.sv */
`timescale 1ns / 100ps

module tb_stable_priority_queue_top;

    import spq_pkg::*;

    localparam int QDEPTH    = 16;
    localparam int TAG_W     = 16;
    localparam int MAX_GAP   = 17;
    localparam int SETTLE    = 8;

    typedef struct packed {
        logic [1:0]           req;
        logic [EXT_TAG_W-1:0] tag;
        logic [PRI_W-1:0]     pri;
    } request_t;

    typedef struct packed {
        logic [1:0]           st;
        logic [EXT_TAG_W-1:0] tag;
        logic [PRI_W-1:0]     pri;
        logic                 lst;
    } reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           req_type = REQ_NONE;
    logic [EXT_TAG_W-1:0] entry_tag = '0;
    logic [PRI_W-1:0]     entry_priority = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [EXT_TAG_W-1:0] out_tag;
    logic [PRI_W-1:0]     out_priority;
    logic                 last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PRIORITY_MIN;
    logic [PRI_W-1:0]     cfg_data = '0;

    // shadow of the sorted queue and its window
    logic [EXT_TAG_W-1:0] shadow_tag [QDEPTH];
    logic [PRI_W-1:0]     shadow_pri [QDEPTH];
    int                   stored = 0;
    logic [PRI_W-1:0]     win_lo = PRIORITY_MIN_RST;
    logic [PRI_W-1:0]     win_hi = PRIORITY_MAX_RST;

    request_t req_backlog [$];
    reply_t   due_replies [$];
    request_t cur_req;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;
    int       mismatch_count = 0;

    stable_priority_queue_top #(
        .QUEUE_DEPTH(QDEPTH),
        .TAG_BITS   (TAG_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .entry_tag     (entry_tag),
        .entry_priority(entry_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_tag       (out_tag),
        .out_priority  (out_priority),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void post_reply(logic [1:0] st, logic [EXT_TAG_W-1:0] tag,
                                       logic [PRI_W-1:0] pri, logic lst);
        reply_t r;
        r.st  = st;
        r.tag = tag;
        r.pri = pri;
        r.lst = lst;
        due_replies.push_back(r);
    endfunction

    // advances the shadow queue by one accepted item and queues its replies
    function automatic void serve_request(request_t it);
        int pos;
        int i;
        case (it.req)
            REQ_INSERT:
            begin
                if (it.pri < win_lo || it.pri > win_hi)
                    post_reply(ST_RANGE, '0, '0, 1'b1);
                else if (stored >= QDEPTH)
                    post_reply(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    // goes behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < stored && shadow_pri[pos] >= it.pri)
                        pos++;
                    for (i = stored; i > pos; i--)
                    begin
                        shadow_tag[i] = shadow_tag[i-1];
                        shadow_pri[i] = shadow_pri[i-1];
                    end
                    shadow_tag[pos] = it.tag;
                    shadow_pri[pos] = it.pri;
                    stored++;
                    post_reply(ST_OK, '0, '0, 1'b1);
                end
            end
            REQ_REMOVE:
            begin
                if (stored == 0)
                    post_reply(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    post_reply(ST_OK, shadow_tag[0], shadow_pri[0], 1'b1);
                    for (i = 1; i < stored; i++)
                    begin
                        shadow_tag[i-1] = shadow_tag[i];
                        shadow_pri[i-1] = shadow_pri[i];
                    end
                    stored--;
                end
            end
            REQ_LIST:
            begin
                if (stored == 0)
                    post_reply(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (i = 0; i < stored; i++)
                        post_reply(ST_OK, shadow_tag[i], shadow_pri[i], i == stored - 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : drive_proc
        logic busy;
        busy = in_valid;
        if (in_valid && !in_stall)
        begin
            serve_request(cur_req);
            busy = 1'b0;
        end
        if (rst_n && !busy)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (req_backlog.size() != 0)
            begin
                cur_req = req_backlog.pop_front();
                req_type       <= cur_req.req;
                entry_tag      <= cur_req.tag;
                entry_priority <= cur_req.pri;
                busy = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    tx_calm = !tx_calm;
                gap_left = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
        in_valid <= busy;
    end

    always @(posedge clk)
    begin : watch_proc
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: status %0d tag %h pri %0d last %0b",
                             status, out_tag, out_priority, last);
            end
            else
            begin
                want = due_replies.pop_front();
                if (status !== want.st || out_tag !== want.tag ||
                    out_priority !== want.pri || last !== want.lst)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected status %0d tag %h pri %0d last %0b",
                                 want.st, want.tag, want.pri, want.lst);
                        $display("          got status %0d tag %h pri %0d last %0b",
                                 status, out_tag, out_priority, last);
                    end
                end
            end
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            hold_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic push_req(logic [1:0] r, logic [EXT_TAG_W-1:0] t, logic [PRI_W-1:0] p);
        request_t it;
        it.req = r;
        it.tag = t;
        it.pri = p;
        req_backlog.push_back(it);
    endtask

    // alternates fill-heavy and drain-heavy stretches so the queue runs full and empty
    task automatic push_random(int n);
        request_t it;
        bit filling;
        int roll;
        int k;
        filling = 1'($urandom_range(0, 1));
        for (k = 0; k < n; k++)
        begin
            if (k % 30 == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                it.req = REQ_NONE;
            else if (roll < (filling ? 72 : 20))
                it.req = REQ_INSERT;
            else if (roll < (filling ? 88 : 85))
                it.req = REQ_REMOVE;
            else
                it.req = REQ_LIST;
            it.tag = EXT_TAG_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 15 || win_lo > win_hi)
                it.pri = PRI_W'($urandom_range(0, 127));
            else if (roll < 55)
                // narrow band near the bottom of the window gives many ties
                it.pri = PRI_W'($urandom_range(win_lo,
                                               (win_lo + 3 > win_hi) ? win_hi : win_lo + 3));
            else
                it.pri = PRI_W'($urandom_range(win_lo, win_hi));
            req_backlog.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_valid || due_replies.size() != 0)
            @(posedge clk);
        // ignored items may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PRI_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRIORITY_MIN)
            win_lo = val;
        else if (idx == CFG_PRIORITY_MAX)
            win_hi = val;
    endtask

    initial
    begin : stim_proc
        int p;
        logic [PRI_W-1:0] lo;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window 15..89
        push_req(REQ_REMOVE, 16'h0000, 7'd0);
        push_req(REQ_LIST,   16'h0000, 7'd0);
        push_req(REQ_NONE,   16'hFFFF, 7'd127);
        push_req(REQ_INSERT, 16'hFFFF, 7'd14);
        push_req(REQ_INSERT, 16'hFFFF, 7'd90);
        push_req(REQ_INSERT, 16'hFFFF, 7'd0);
        push_req(REQ_INSERT, 16'hFFFF, 7'd127);
        push_req(REQ_INSERT, 16'h0000, 7'd15);
        push_req(REQ_INSERT, 16'hFFFF, 7'd89);
        push_req(REQ_INSERT, 16'h1111, 7'd50);
        push_req(REQ_INSERT, 16'h2222, 7'd50);
        push_req(REQ_INSERT, 16'h3333, 7'd50);
        push_req(REQ_INSERT, 16'h0001, 7'd16);
        push_req(REQ_LIST,   16'h0000, 7'd0);
        push_req(REQ_REMOVE, 16'h0000, 7'd0);
        push_req(REQ_REMOVE, 16'h0000, 7'd0);
        push_req(REQ_NONE,   16'h0000, 7'd0);
        push_req(REQ_LIST,   16'h0000, 7'd0);
        push_req(REQ_INSERT, 16'h5A5A, 7'd50);
        push_req(REQ_LIST,   16'h0000, 7'd0);
        wait_idle();

        write_reg(CFG_PRIORITY_MIN, 7'd0);
        write_reg(CFG_PRIORITY_MAX, 7'd127);
        push_random(150);
        wait_idle();

        // inverted window rejects every insert
        write_reg(CFG_PRIORITY_MIN, 7'd127);
        write_reg(CFG_PRIORITY_MAX, 7'd0);
        push_random(20);
        wait_idle();

        // single-value window: every accepted insert has the same priority
        write_reg(CFG_PRIORITY_MIN, 7'd64);
        write_reg(CFG_PRIORITY_MAX, 7'd64);
        write_reg(2'd2, 7'd0);
        write_reg(2'd3, 7'd127);
        push_random(50);
        wait_idle();

        for (p = 0; p < 4; p++)
        begin
            lo = PRI_W'($urandom_range(0, 100));
            write_reg(CFG_PRIORITY_MIN, lo);
            write_reg(CFG_PRIORITY_MAX, PRI_W'($urandom_range(lo, 127)));
            write_reg(CFG_IDX_W'($urandom_range(2, 3)), PRI_W'($urandom_range(0, 127)));
            push_random(65);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && due_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
